// ===== design/ccdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ccdp_pkg
// Types and constants shared by the caption distribution packet parser.
// ----------------------------------------------------------------------------
package ccdp_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_packet;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  item_kind;
		logic [2:0]  status;
		logic [3:0]  rate_code;
		logic [15:0] sequence_value;
		logic [7:0]  flag_bits;
		logic [5:0]  tc_hours;
		logic [6:0]  tc_minutes;
		logic [6:0]  tc_seconds;
		logic [5:0]  tc_frames;
		logic [23:0] payload_word;
		logic [5:0]  service_number;
		logic        last_item;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  b;
		logic        eop;
		logic [7:0]  pos;
		logic [7:0]  sum;
	} cls_item_t;

	localparam logic [2:0] CFG_IDENT = 3'd0;
	localparam logic [2:0] CFG_TC    = 3'd1;
	localparam logic [2:0] CFG_CC    = 3'd2;
	localparam logic [2:0] CFG_SVC   = 3'd3;
	localparam logic [2:0] CFG_FOOT  = 3'd4;

	localparam logic [2:0] K_HDR  = 3'd0;
	localparam logic [2:0] K_TC   = 3'd1;
	localparam logic [2:0] K_CC   = 3'd2;
	localparam logic [2:0] K_SVC  = 3'd3;
	localparam logic [2:0] K_XTRA = 3'd4;
	localparam logic [2:0] K_END  = 3'd5;

	localparam logic [2:0] E_NONE  = 3'd0;
	localparam logic [2:0] E_SHORT = 3'd1;
	localparam logic [2:0] E_IDENT = 3'd2;
	localparam logic [2:0] E_LEN   = 3'd3;
	localparam logic [2:0] E_SUM   = 3'd4;
	localparam logic [2:0] E_SECT  = 3'd5;
	localparam logic [2:0] E_FID   = 3'd6;
	localparam logic [2:0] E_FSEQ  = 3'd7;

	localparam logic [8:0] MIN_BYTES = 9'd11;

	localparam logic [3:0] PH_HDR     = 4'd0;
	localparam logic [3:0] PH_AT_TC   = 4'd1;
	localparam logic [3:0] PH_TC      = 4'd2;
	localparam logic [3:0] PH_AT_CC   = 4'd3;
	localparam logic [3:0] PH_CCCOUNT = 4'd4;
	localparam logic [3:0] PH_CC      = 4'd5;
	localparam logic [3:0] PH_AT_SVC  = 4'd6;
	localparam logic [3:0] PH_SVCFLAG = 4'd7;
	localparam logic [3:0] PH_SVC     = 4'd8;
	localparam logic [3:0] PH_TAIL    = 4'd9;
	localparam logic [3:0] PH_FOOT    = 4'd10;
	localparam logic [3:0] PH_SKIP    = 4'd11;

endpackage

// ===== design/ccdp_front.sv =====
// ----------------------------------------------------------------------------
// ccdp_front
// Accepts bytes, tracks position and running checksum, pushes into the queue.
// ----------------------------------------------------------------------------
module ccdp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ccdp_pkg::in_item_t   in_data,
	input  logic                 q_full,
	output logic                 in_stall,
	output logic                 push,
	output ccdp_pkg::cls_item_t  push_data
);
	import ccdp_pkg::*;

	logic [7:0] pos_q;
	logic [7:0] sum_q;
	logic [7:0] sum_nx;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign sum_nx   = sum_q + in_data.in_byte;

	always_comb begin
		push_data.valid = 1'b1;
		push_data.b     = in_data.in_byte;
		push_data.eop   = in_data.end_of_packet;
		push_data.pos   = pos_q;
		push_data.sum   = sum_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (push) begin
			if (in_data.end_of_packet) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= (pos_q == 8'd255) ? pos_q : pos_q + 8'd1;
				sum_q <= sum_nx;
			end
		end
	end
endmodule

// ===== design/ccdp_fifo.sv =====
// ----------------------------------------------------------------------------
// ccdp_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module ccdp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ccdp_pkg::cls_item_t  push_data,
	input  logic                 pop,
	output logic                 full,
	output logic                 not_empty,
	output ccdp_pkg::cls_item_t  head
);
	import ccdp_pkg::*;

	cls_item_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== design/ccdp_back.sv =====
// ----------------------------------------------------------------------------
// ccdp_back
// Walks the packet sections and builds result items into an output register.
// ----------------------------------------------------------------------------
module ccdp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  ccdp_pkg::cls_item_t  q_head,
	output logic                 pop,
	input  logic [15:0]          cfg_ident,
	input  logic [7:0]           cfg_tc_id,
	input  logic [7:0]           cfg_cc_id,
	input  logic [7:0]           cfg_svc_id,
	input  logic [7:0]           cfg_foot_id,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ccdp_pkg::out_item_t  out_data
);
	import ccdp_pkg::*;

	logic [3:0]  ph_q, ph_n;
	logic [7:0]  dlen_q, dlen_n;
	logic [4:0]  left_q, left_n;
	logic [2:0]  idx_q, idx_n;
	logic [15:0] hseq_q, hseq_n;
	logic [6:0]  hflag_q, hflag_n;
	logic [3:0]  rate_q, rate_n;
	logic [2:0]  err_q, err_n;
	logic [47:0] asm_q, asm_n;
	logic [2:0]  sflag_q, sflag_n;
	logic [3:0]  mis_q, mis_n;
	logic [7:0]  fseq_hi_q, fseq_hi_n;
	logic        ov_q;
	out_item_t   ov_data_q;
	out_item_t   it;
	logic        emit;

	logic [7:0]  b, pos;
	logic [9:0]  p9, dl;
	logic [5:0]  csn;
	logic [7:0]  fl, d4, f, b1, b2, b3;
	logic [4:0]  ccnt;
	logic [3:0]  scnt;
	logic        go;

	assign go        = q_valid && (!ov_q || !out_stall);
	assign pop       = go;
	assign out_valid = ov_q;
	assign out_data  = ov_data_q;

	always_comb begin
		logic st_done;
		logic [2:0] st;
		b  = q_head.b;
		pos = q_head.pos;
		p9 = {2'b00, pos};
		dl = {2'b00, dlen_q};
		ph_n = ph_q; dlen_n = dlen_q; left_n = left_q; idx_n = idx_q;
		hseq_n = hseq_q; hflag_n = hflag_q; rate_n = rate_q; err_n = err_q;
		asm_n = asm_q; sflag_n = sflag_q; mis_n = mis_q; fseq_hi_n = fseq_hi_q;
		it = '0; emit = 1'b0; st_done = 1'b0; st = E_NONE;
		fl = asm_q[7:0]; d4 = asm_q[39:32]; f = asm_q[47:40];
		b1 = asm_q[7:0]; b2 = asm_q[15:8]; b3 = asm_q[23:16];
		csn = fl[6] ? {1'b0, fl[4:0]} : fl[5:0];
		ccnt = b[4:0]; scnt = b[3:0];
		case (ph_q)
			PH_HDR: begin
				case (pos)
					8'd0: asm_n[7:0] = b;
					8'd1: if ({asm_q[7:0], b} != cfg_ident && err_n == E_NONE) err_n = E_IDENT;
					8'd2: dlen_n = b;
					8'd3: rate_n = b[7:4];
					8'd4: begin hflag_n = b[7:1]; sflag_n = b[4:2]; end
					8'd5: hseq_n = {b, 8'h00};
					8'd6: begin
						hseq_n = {hseq_q[15:8], b};
						it.item_kind = K_HDR; it.rate_code = rate_q;
						it.sequence_value = hseq_n; it.flag_bits = {hflag_q, 1'b0};
						emit = 1'b1; ph_n = PH_AT_TC;
					end
					default: ph_n = PH_SKIP;
				endcase
			end
			PH_TC: begin
				if (idx_q < 3'd3) begin
					asm_n[idx_q[1:0]*8 +: 8] = b; idx_n = idx_q + 3'd1;
				end else begin
					it.item_kind = K_TC;
					it.flag_bits = {6'd0, b3[7], b[7]};
					it.tc_hours   = 6'({2'b0, b1[5:4]} * 4'd10 + {2'b0, b1[3:0]});
					it.tc_minutes = 7'({1'b0, b2[6:4]} * 4'd10 + {3'b0, b2[3:0]});
					it.tc_seconds = 7'({1'b0, b3[6:4]} * 4'd10 + {3'b0, b3[3:0]});
					it.tc_frames  = 6'({2'b0, b[5:4]} * 4'd10 + {2'b0, b[3:0]});
					emit = 1'b1; idx_n = '0; ph_n = PH_AT_CC;
				end
			end
			PH_CCCOUNT: begin
				if (p9 + 10'd5 + 10'(ccnt) * 10'd3 > dl) begin
					ph_n = PH_SKIP; if (err_n == E_NONE) err_n = E_SECT;
				end else if (ccnt == 5'd0) ph_n = PH_AT_SVC;
				else begin left_n = ccnt; idx_n = '0; ph_n = PH_CC; end
			end
			PH_CC: begin
				if (idx_q < 3'd2) begin
					asm_n[idx_q[0]*8 +: 8] = b; idx_n = idx_q + 3'd1;
				end else begin
					it.item_kind = K_CC; it.flag_bits = {5'd0, b1[2:0]};
					it.payload_word = {8'd0, b2, b};
					emit = 1'b1; idx_n = '0; left_n = left_q - 5'd1;
					if (left_n == 5'd0) ph_n = PH_AT_SVC;
				end
			end
			PH_SVCFLAG: begin
				sflag_n = b[6:4];
				if (p9 + 10'd5 + 10'(scnt) * 10'd7 > dl) begin
					ph_n = PH_SKIP; if (err_n == E_NONE) err_n = E_SECT;
				end else if (scnt == 4'd0) ph_n = PH_TAIL;
				else begin left_n = {1'b0, scnt}; idx_n = '0; ph_n = PH_SVC; end
			end
			PH_SVC: begin
				if (idx_q < 3'd6) begin
					asm_n[idx_q*8 +: 8] = b; idx_n = idx_q + 3'd1;
				end else begin
					if (d4[7] && d4[5:0] != csn && mis_q < 4'd15) mis_n = mis_q + 4'd1;
					it.item_kind = K_SVC;
					it.flag_bits = {3'd0, fl[6], d4[7], d4[7] ? 1'b0 : d4[0], f[7], f[6]};
					it.payload_word = {asm_q[15:8], asm_q[23:16], asm_q[31:24]};
					it.service_number = csn;
					emit = 1'b1; idx_n = '0; left_n = left_q - 5'd1;
					if (left_n == 5'd0) ph_n = PH_TAIL;
				end
			end
			PH_FOOT: begin
				if (idx_q == 3'd0) begin fseq_hi_n = b; idx_n = 3'd1; end
				else begin
					if ({fseq_hi_q, b} != hseq_q && err_n == E_NONE) err_n = E_FSEQ;
					ph_n = PH_SKIP;
				end
			end
			PH_AT_TC, PH_AT_CC, PH_AT_SVC, PH_TAIL: begin
				st_done = 1'b0;
				if (ph_q == PH_AT_TC && hflag_q[6]) begin
					if (p9 + 10'd9 > dl || b != cfg_tc_id) begin
						ph_n = PH_SKIP; if (err_n == E_NONE) err_n = E_SECT;
					end else begin ph_n = PH_TC; idx_n = '0; end
					st_done = 1'b1;
				end else if ((ph_q == PH_AT_TC || ph_q == PH_AT_CC) && hflag_q[5]) begin
					if (p9 + 10'd6 > dl || b != cfg_cc_id) begin
						ph_n = PH_SKIP; if (err_n == E_NONE) err_n = E_SECT;
					end else ph_n = PH_CCCOUNT;
					st_done = 1'b1;
				end else if (ph_q != PH_TAIL && p9 + 10'd6 <= dl && b == cfg_svc_id) begin
					ph_n = PH_SVCFLAG;
					st_done = 1'b1;
				end
				if (!st_done) begin
					if (p9 + 10'd4 < dl) begin
						it.item_kind = K_XTRA; it.payload_word = {16'd0, b};
						emit = 1'b1; ph_n = PH_TAIL;
					end else begin
						if (b != cfg_foot_id && err_n == E_NONE) err_n = E_FID;
						ph_n = PH_FOOT; idx_n = '0;
					end
				end
			end
			default: ;
		endcase
		if (q_head.eop) begin
			if (p9 + 10'd1 < {1'b0, MIN_BYTES}) st = E_SHORT;
			else if (err_n == E_IDENT) st = E_IDENT;
			else if (pos == 8'd255 || dlen_n != pos + 8'd1) st = E_LEN;
			else if (q_head.sum != 8'd0) st = E_SUM;
			else st = err_n;
			it = '0;
			it.item_kind = K_END; it.status = st; it.flag_bits = {5'd0, sflag_n};
			it.payload_word = {20'd0, mis_n}; it.last_item = 1'b1;
			emit = 1'b1;
			ph_n = PH_HDR; dlen_n = '0; left_n = '0; idx_n = '0; hseq_n = '0;
			hflag_n = '0; rate_n = '0; err_n = E_NONE; sflag_n = '0; mis_n = '0;
			fseq_hi_n = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) asm_q <= asm_n;
		if (go && emit) ov_data_q <= it;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HDR; dlen_q <= '0; left_q <= '0; idx_q <= '0;
			hseq_q <= '0; hflag_q <= '0; rate_q <= '0; err_q <= E_NONE;
			sflag_q <= '0; mis_q <= '0; fseq_hi_q <= '0; ov_q <= 1'b0;
		end else begin
			if (go) begin
				ph_q <= ph_n; dlen_q <= dlen_n; left_q <= left_n; idx_q <= idx_n;
				hseq_q <= hseq_n; hflag_q <= hflag_n; rate_q <= rate_n;
				err_q <= err_n; sflag_q <= sflag_n; mis_q <= mis_n;
				fseq_hi_q <= fseq_hi_n;
			end
			if (go) ov_q <= emit;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end
endmodule

// ===== design/caption_cdp_packet_parser_core.sv =====
// ----------------------------------------------------------------------------
// caption_cdp_packet_parser_core
// Caption distribution packet parser: one byte in, at most one item out.
// Throughput: one byte per cycle while out_stall is low; a held output backs up into the queue and stalls input.
// Path: an accepted byte is stored in the queue, then its item is registered in the output register.
// Reset: clears packet state, queue and output; registers take their default ids.
// ----------------------------------------------------------------------------
module caption_cdp_packet_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ccdp_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ccdp_pkg::out_item_t  out_data,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);
	import ccdp_pkg::*;

	logic [15:0] ident_q;
	logic [7:0]  tc_id_q, cc_id_q, svc_id_q, foot_id_q;
	logic        push, pop, full, not_empty;
	cls_item_t   push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ident_q <= 16'h9669; tc_id_q <= 8'h71; cc_id_q <= 8'h72;
			svc_id_q <= 8'h73; foot_id_q <= 8'h74;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDENT: ident_q <= cfg_wdata;
				CFG_TC:    tc_id_q <= cfg_wdata[7:0];
				CFG_CC:    cc_id_q <= cfg_wdata[7:0];
				CFG_SVC:   svc_id_q <= cfg_wdata[7:0];
				CFG_FOOT:  foot_id_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	ccdp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_data(in_data),
		.q_full(full), .in_stall(in_stall), .push(push), .push_data(push_data)
	);

	ccdp_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(pop), .full(full), .not_empty(not_empty), .head(head)
	);

	ccdp_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(not_empty), .q_head(head), .pop(pop),
		.cfg_ident(ident_q), .cfg_tc_id(tc_id_q), .cfg_cc_id(cc_id_q),
		.cfg_svc_id(svc_id_q), .cfg_foot_id(foot_id_q),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);
endmodule

// ===== design/ccdp_checker.sv =====
// ----------------------------------------------------------------------------
// ccdp_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module ccdp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input ccdp_pkg::out_item_t  out_data
);
	import ccdp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled item changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_item == (out_data.item_kind == K_END)))
		else $error("last flag mismatch");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.item_kind <= K_END)
		else $error("bad kind");

	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.item_kind != K_END |-> out_data.status == E_NONE)
		else $error("status on non-end item");
endmodule

bind caption_cdp_packet_parser_core ccdp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid),
	.out_stall(out_stall), .out_data(out_data)
);
